### rtl/sor_pkg.sv
// ----------------------------------------------------------------------------
// sor_pkg
// Shared types, codes and helpers of the over-relaxation grid unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sor_pkg;

  localparam int VALUE_BITS  = 32;
  localparam int FRAC_BITS   = 16;
  localparam int FACTOR_FRAC = 14;

  localparam logic [2:0] OP_WR_FLUX = 3'd0;
  localparam logic [2:0] OP_WR_SRC  = 3'd1;
  localparam logic [2:0] OP_WR_COEF = 3'd2;
  localparam logic [2:0] OP_SWEEP   = 3'd3;
  localparam logic [2:0] OP_RD_FLUX = 3'd4;

  localparam logic [1:0] CFG_ROWS   = 2'd0;
  localparam logic [1:0] CFG_COLS   = 2'd1;
  localparam logic [1:0] CFG_VCOEF  = 2'd2;
  localparam logic [1:0] CFG_FACTOR = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_FACTOR,
    ST_CELL,
    ST_FINISH,
    ST_RESULT
  } main_state_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_DIV_RATIO,
    FS_SQRT,
    FS_DIV_FACTOR
  } fac_state_t;

  typedef struct packed {
    logic        start;
    logic [1:0]  sweeps;
    logic [30:0] latest;
    logic [30:0] earlier;
    logic [14:0] init_factor;
  } fac_req_t;

  typedef struct packed {
    logic        done;
    logic [14:0] factor;
  } fac_rsp_t;

  function automatic logic signed [VALUE_BITS-1:0] sat_val(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) begin
      return VALUE_BITS'(hi);
    end else if (v < lo) begin
      return VALUE_BITS'(lo);
    end
    return VALUE_BITS'(v);
  endfunction

endpackage

`default_nettype wire

### rtl/sor_factor.sv
// ----------------------------------------------------------------------------
// sor_factor
// Relaxation factor estimate: ratio division, integer square root and the
// final division, each one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sor_factor (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sor_pkg::fac_req_t req,
  output      sor_pkg::fac_rsp_t rsp
);
  import sor_pkg::*;

  fac_state_t  state_r;
  logic [4:0]  cnt_r;
  logic [32:0] rem_r;
  logic [30:0] den_r;
  logic [29:0] quo_r;
  logic [28:0] x_r;
  logic [29:0] root_r;
  logic [28:0] bit_r;
  logic        done_r;
  logic [14:0] factor_r;

  logic [32:0] shifted;
  logic        ge;
  logic [32:0] rem_nxt;
  logic [29:0] quo_nxt;
  logic [29:0] trial;
  logic        take;
  logic [28:0] x_nxt;
  logic [29:0] root_nxt;
  logic        fallback;

  always_comb begin
    shifted  = {rem_r[31:0], 1'b0};
    ge       = shifted >= {2'b00, den_r};
    rem_nxt  = ge ? shifted - {2'b00, den_r} : shifted;
    quo_nxt  = {quo_r[28:0], ge};
    trial    = root_r + {1'b0, bit_r};
    take     = {1'b0, x_r} >= trial;
    x_nxt    = take ? 29'({1'b0, x_r} - trial) : x_r;
    root_nxt = take ? (root_r >> 1) + {1'b0, bit_r} : (root_r >> 1);
    fallback = (req.sweeps < 2'd2) || (req.earlier == '0) || (req.latest >= req.earlier);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= ((state_r == FS_IDLE) && req.start && fallback)
             || ((state_r == FS_DIV_FACTOR) && (cnt_r == 5'd1));
      unique case (state_r)
        FS_IDLE: begin
          if (req.start) begin
            if (fallback) begin
              factor_r <= req.init_factor;
            end else begin
              state_r <= FS_DIV_RATIO;
              rem_r   <= {2'b00, req.latest};
              den_r   <= req.earlier;
              quo_r   <= '0;
              cnt_r   <= 5'd28;
            end
          end
        end
        FS_DIV_RATIO: begin
          rem_r <= rem_nxt;
          quo_r <= quo_nxt;
          if (cnt_r == 5'd1) begin
            state_r <= FS_SQRT;
            x_r     <= 29'h1000_0000 - quo_nxt[28:0];
            root_r  <= '0;
            bit_r   <= 29'h1000_0000;
            cnt_r   <= 5'd15;
          end else begin
            cnt_r <= cnt_r - 5'd1;
          end
        end
        FS_SQRT: begin
          x_r    <= x_nxt;
          root_r <= root_nxt;
          bit_r  <= bit_r >> 2;
          if (cnt_r == 5'd1) begin
            state_r <= FS_DIV_FACTOR;
            den_r   <= 31'h0000_4000 + 31'(root_nxt);
            rem_r   <= 33'd1;
            quo_r   <= '0;
            cnt_r   <= 5'd29;
          end else begin
            cnt_r <= cnt_r - 5'd1;
          end
        end
        FS_DIV_FACTOR: begin
          rem_r <= rem_nxt;
          quo_r <= quo_nxt;
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == 5'd1) begin
            state_r  <= FS_IDLE;
            factor_r <= (quo_nxt > 30'd32767) ? 15'h7FFF : quo_nxt[14:0];
          end
        end
        default: state_r <= FS_IDLE;
      endcase
    end
  end

  assign rsp.done   = done_r;
  assign rsp.factor = factor_r;

endmodule

`default_nettype wire

### rtl/sor_grid_relaxation_unit.sv
// ----------------------------------------------------------------------------
// sor_grid_relaxation_unit
// Over-relaxation on a five-point stencil over a flux grid held in memory.
// ----------------------------------------------------------------------------
// Input transactions carry an operation in in_tuser: load flux, load source,
// load row coefficients, run a sweep or read flux. Every transaction gives
// exactly one result on the out_ channel (read data, last sweep change,
// last factor, sweep flag in out_tuser).
// Loads and unknown operations fill the output register when accepted; a
// flux read goes through the read and result states. A sweep first
// estimates the factor (the initial factor on fallback, otherwise a 28-step
// division, a 15-step square root and a 29-step division), then visits each
// interior cell in turn, the single flux memory port reading the five
// stencil cells one after another and the multiplier being shared.
// One item is worked on at a time. A result waits in the output register
// while the receiver stalls; a new transaction is taken only when that
// register is free or being emptied. Reset clears the control state and
// change history and restores the register defaults; grid and coefficient
// memories hold nothing defined until written. Configuration must be written
// on cfg_ only while the unit is idle; the unit does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module sor_grid_relaxation_unit #(
  parameter int ROWS_MAX = 64,
  parameter int COLS_MAX = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  // row[5:0], col[11:6], value[43:12], outer_value[75:44], zero fill
  input  wire logic [79:0] in_tdata,
  // operation
  input  wire logic [2:0]  in_tuser,
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  // read_data[31:0], max_change[62:32], factor_used[77:63], zero fill
  output      logic [79:0] out_tdata,
  // sweep_done
  output      logic        out_tuser,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [16:0] cfg_wdata
);
  import sor_pkg::*;

  localparam int DEPTH   = ROWS_MAX * COLS_MAX;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int RI_W    = $clog2(ROWS_MAX);
  localparam int CJ_W    = $clog2(COLS_MAX);
  localparam int R_LIM_W = ($clog2(ROWS_MAX + 1) > 7) ? $clog2(ROWS_MAX + 1) : 7;
  localparam int C_LIM_W = ($clog2(COLS_MAX + 1) > 7) ? $clog2(COLS_MAX + 1) : 7;
  localparam int ACC_W   = 51;

  localparam logic [2:0] STEP_UP    = 3'd0;
  localparam logic [2:0] STEP_DOWN  = 3'd1;
  localparam logic [2:0] STEP_LEFT  = 3'd2;
  localparam logic [2:0] STEP_RIGHT = 3'd3;
  localparam logic [2:0] STEP_CTR   = 3'd4;
  localparam logic [2:0] STEP_OLD   = 3'd5;
  localparam logic [2:0] STEP_BLEND = 3'd6;
  localparam logic [2:0] STEP_WB    = 3'd7;

  // configuration
  logic [6:0]  rows_used_r;
  logic [6:0]  cols_used_r;
  logic [16:0] vcoef_r;
  logic [14:0] init_factor_r;

  // sweep history
  logic [30:0] latest_r;
  logic [30:0] earlier_r;
  logic [1:0]  sweeps_r;
  logic [14:0] last_factor_r;

  main_state_t state_r, state_nxt;
  logic [2:0]      step_r;
  logic [RI_W-1:0] i_r;
  logic [CJ_W-1:0] j_r;
  logic [14:0]     w_r;
  logic [31:0]     worst_r;

  // memories
  logic signed [31:0] flux_mem  [DEPTH];
  logic signed [31:0] src_mem   [DEPTH];
  logic signed [31:0] inner_mem [ROWS_MAX];
  logic signed [31:0] outer_mem [ROWS_MAX];
  logic signed [31:0] flux_dout_r;
  logic signed [31:0] src_dout_r;
  logic signed [31:0] inner_dout_r;
  logic signed [31:0] outer_dout_r;

  // datapath
  logic signed [65:0]    prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [31:0]    old_r;
  logic signed [32:0]    mul_a;
  logic signed [32:0]    mul_b;
  logic signed [31:0]    g_val;
  logic signed [32:0]    diff;
  logic signed [35:0]    nv_sum;
  logic signed [31:0]    nv;
  logic signed [32:0]    ch_s;
  logic [31:0]           ch_abs;

  // output register
  logic        out_valid_r;
  logic [31:0] out_rd_r;
  logic [30:0] out_max_r;
  logic [14:0] out_fac_r;
  logic        out_sweep_r;
  logic [31:0] res_rd_r;
  logic        res_sweep_r;
  logic        rd_inside_r;

  // input decode
  logic [2:0]         op;
  logic [5:0]         in_row;
  logic [5:0]         in_col;
  logic signed [31:0] in_val;
  logic signed [31:0] in_outer;
  logic               in_range;
  logic               row_ok;
  logic [ADDR_W-1:0]  in_addr;
  logic               accept;
  logic               out_free;
  logic               load_out;

  logic [R_LIM_W-1:0] nr_lim;
  logic [C_LIM_W-1:0] nc_lim;
  logic               tiny;
  logic               last_row;
  logic               last_col;
  logic [ADDR_W-1:0]  k_addr;
  logic [ADDR_W-1:0]  flux_raddr;
  logic [ADDR_W-1:0]  flux_waddr;
  logic signed [31:0] flux_wdata;
  logic               flux_we;

  fac_req_t fac_req;
  fac_rsp_t fac_rsp;

  always_comb begin
    op       = in_tuser;
    in_row   = in_tdata[5:0];
    in_col   = in_tdata[11:6];
    in_val   = in_tdata[43:12];
    in_outer = in_tdata[75:44];
    row_ok   = int'(in_row) < ROWS_MAX;
    in_range = row_ok && (int'(in_col) < COLS_MAX);
    in_addr  = ADDR_W'(int'(in_row) * COLS_MAX + int'(in_col));
    out_free = !out_valid_r || out_tready;
    in_tready = (state_r == ST_IDLE) && out_free;
    accept   = in_tvalid && in_tready;
  end

  always_comb begin
    nr_lim = (R_LIM_W'(rows_used_r) > R_LIM_W'(ROWS_MAX)) ? R_LIM_W'(ROWS_MAX)
                                                          : R_LIM_W'(rows_used_r);
    nc_lim = (C_LIM_W'(cols_used_r) > C_LIM_W'(COLS_MAX)) ? C_LIM_W'(COLS_MAX)
                                                          : C_LIM_W'(cols_used_r);
    tiny     = (nr_lim < R_LIM_W'(3)) || (nc_lim < C_LIM_W'(3));
    last_row = R_LIM_W'(i_r) == nr_lim - R_LIM_W'(2);
    last_col = C_LIM_W'(j_r) == nc_lim - C_LIM_W'(2);
    k_addr   = ADDR_W'(int'(i_r) * COLS_MAX + int'(j_r));
  end

  assign fac_req.start       = accept && (op == OP_SWEEP);
  assign fac_req.sweeps      = sweeps_r;
  assign fac_req.latest      = latest_r;
  assign fac_req.earlier     = earlier_r;
  assign fac_req.init_factor = init_factor_r;

  sor_factor u_factor (
    .clk (clk),
    .rst_n (rst_n),
    .req (fac_req),
    .rsp (fac_rsp)
  );

  // stencil arithmetic
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_r)
      STEP_DOWN: begin
        mul_a = 33'(inner_dout_r);
        mul_b = 33'(flux_dout_r);
      end
      STEP_LEFT: begin
        mul_a = 33'(outer_dout_r);
        mul_b = 33'(flux_dout_r);
      end
      STEP_RIGHT, STEP_CTR: begin
        mul_a = $signed({16'b0, vcoef_r});
        mul_b = 33'(flux_dout_r);
      end
      STEP_BLEND: begin
        mul_a = diff;
        mul_b = $signed({18'b0, w_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    g_val  = sat_val(64'(acc_r));
    diff   = 33'(g_val) - 33'(old_r);
    nv_sum = 36'(old_r) + 36'(prod_r >>> FACTOR_FRAC);
    nv     = sat_val(64'(nv_sum));
    ch_s   = 33'(nv) - 33'(old_r);
    ch_abs = ch_s[32] ? 32'(-ch_s) : ch_s[31:0];
  end

  // memory ports
  always_comb begin
    flux_raddr = in_addr;
    if (state_r == ST_CELL) begin
      case (step_r)
        STEP_UP:    flux_raddr = k_addr - ADDR_W'(COLS_MAX);
        STEP_DOWN:  flux_raddr = k_addr + ADDR_W'(COLS_MAX);
        STEP_LEFT:  flux_raddr = k_addr - ADDR_W'(1);
        STEP_RIGHT: flux_raddr = k_addr + ADDR_W'(1);
        default:    flux_raddr = k_addr;
      endcase
    end
    flux_we    = (accept && (op == OP_WR_FLUX) && in_range)
              || ((state_r == ST_CELL) && (step_r == STEP_WB));
    flux_waddr = (state_r == ST_CELL) ? k_addr : in_addr;
    flux_wdata = (state_r == ST_CELL) ? nv : in_val;
  end

  always_ff @(posedge clk) begin
    if (flux_we) begin
      flux_mem[flux_waddr] <= flux_wdata;
    end
    flux_dout_r <= flux_mem[flux_raddr];
  end

  always_ff @(posedge clk) begin
    if (accept && (op == OP_WR_SRC) && in_range) begin
      src_mem[in_addr] <= in_val;
    end
    src_dout_r <= src_mem[k_addr];
  end

  always_ff @(posedge clk) begin
    if (accept && (op == OP_WR_COEF) && row_ok) begin
      inner_mem[RI_W'(in_row)] <= in_val;
      outer_mem[RI_W'(in_row)] <= in_outer;
    end
    inner_dout_r <= inner_mem[i_r];
    outer_dout_r <= outer_mem[i_r];
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (step_r)
      STEP_DOWN: acc_r <= ACC_W'(src_dout_r);
      STEP_LEFT, STEP_RIGHT, STEP_CTR: acc_r <= acc_r + ACC_W'(prod_r >>> FRAC_BITS);
      STEP_OLD: begin
        acc_r <= acc_r + ACC_W'(prod_r >>> FRAC_BITS);
        old_r <= flux_dout_r;
      end
      default: acc_r <= acc_r;
    endcase
    if (state_r == ST_READ) begin
      res_rd_r <= rd_inside_r ? flux_dout_r : '0;
    end
    if (accept) begin
      rd_inside_r <= in_range;
      res_rd_r    <= '0;
      res_sweep_r <= (op == OP_SWEEP);
    end
    if (fac_rsp.done) begin
      w_r <= fac_rsp.factor;
    end
    if (accept && (op == OP_SWEEP)) begin
      worst_r <= '0;
    end else if ((state_r == ST_CELL) && (step_r == STEP_WB) && (ch_abs > worst_r)) begin
      worst_r <= ch_abs;
    end
  end

  // state machine
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (op == OP_RD_FLUX)) begin
          state_nxt = ST_READ;
        end else if (accept && (op == OP_SWEEP)) begin
          state_nxt = ST_FACTOR;
        end
      end
      ST_READ:   state_nxt = ST_RESULT;
      ST_FACTOR: begin
        if (fac_rsp.done) begin
          state_nxt = tiny ? ST_FINISH : ST_CELL;
        end
      end
      ST_CELL: begin
        if ((step_r == STEP_WB) && last_row && last_col) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: state_nxt = ST_RESULT;
      ST_RESULT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sweep counters, history and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r        <= STEP_UP;
      i_r           <= '0;
      j_r           <= '0;
      latest_r      <= '0;
      earlier_r     <= '0;
      sweeps_r      <= '0;
      last_factor_r <= '0;
      rows_used_r   <= 7'd64;
      cols_used_r   <= 7'd64;
      vcoef_r       <= 17'd16384;
      init_factor_r <= 15'd24576;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_ROWS:   rows_used_r   <= cfg_wdata[6:0];
          CFG_COLS:   cols_used_r   <= cfg_wdata[6:0];
          CFG_VCOEF:  vcoef_r       <= cfg_wdata;
          CFG_FACTOR: init_factor_r <= cfg_wdata[14:0];
          default: ;
        endcase
      end
      if ((state_r == ST_FACTOR) && fac_rsp.done) begin
        step_r <= STEP_UP;
        i_r    <= RI_W'(1);
        j_r    <= CJ_W'(1);
      end else if (state_r == ST_CELL) begin
        step_r <= step_r + 3'd1;
        if (step_r == STEP_WB) begin
          if (last_col) begin
            j_r <= CJ_W'(1);
            if (!last_row) begin
              i_r <= i_r + RI_W'(1);
            end
          end else begin
            j_r <= j_r + CJ_W'(1);
          end
        end
      end
      if (state_r == ST_FINISH) begin
        earlier_r     <= latest_r;
        latest_r      <= worst_r[31] ? 31'h7FFF_FFFF : worst_r[30:0];
        sweeps_r      <= (sweeps_r == 2'd2) ? 2'd2 : sweeps_r + 2'd1;
        last_factor_r <= w_r;
      end
    end
  end

  // output register
  assign load_out = (accept && (op != OP_SWEEP) && (op != OP_RD_FLUX))
                 || ((state_r == ST_RESULT) && out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_rd_r    <= (state_r == ST_RESULT) ? res_rd_r : '0;
      out_sweep_r <= (state_r == ST_RESULT) ? res_sweep_r : 1'b0;
      out_max_r   <= latest_r;
      out_fac_r   <= last_factor_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_fac_r, out_max_r, out_rd_r};
  assign out_tuser  = out_sweep_r;

  // checks
  a_fac_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    fac_rsp.done |-> (state_r == ST_FACTOR))
    else $error("factor result outside sweep set-up");

  a_step_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_CELL) && (step_r == STEP_WB)) |=> (step_r == STEP_UP))
    else $error("cell sequence out of step");

  a_sweeps_sat: assert property (@(posedge clk) disable iff (!rst_n)
    sweeps_r != 2'd3)
    else $error("sweep count beyond saturation");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH) |=> (state_r == ST_RESULT))
    else $error("sweep finished without result");

endmodule

`default_nettype wire
